### src/icwr_pkg.sv
package icwr_pkg;

  localparam int DATA_FRAC_BITS   = 24;
  localparam int WEIGHT_FRAC_BITS = 30;

  localparam int DATA_W  = 32;
  localparam int ACC_W   = 64;
  localparam int MIN_FRAC = (DATA_FRAC_BITS < WEIGHT_FRAC_BITS) ? DATA_FRAC_BITS
                                                                : WEIGHT_FRAC_BITS;
  // Widest product after the smallest truncating shift
  localparam int PROD_W  = 2 * DATA_W - MIN_FRAC;
  localparam int SUM_W   = PROD_W + 1;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic REG_IDX_WEIGHT_LOW  = 1'b0;
  localparam logic REG_IDX_WEIGHT_HIGH = 1'b1;

  localparam logic [DATA_W-1:0] WEIGHT_LOW_RESET  = 32'h4000_0000;
  localparam logic [DATA_W-1:0] WEIGHT_HIGH_RESET = 32'h0000_0000;

  // Multiplier pair operations; also names the combine that follows them
  typedef enum logic [2:0] {
    MOP_NONE,
    MOP_BL_RE,
    MOP_BL_IM,
    MOP_P_RE,
    MOP_P_IM,
    MOP_Q_RE,
    MOP_Q_IM,
    MOP_T
  } icwr_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BL_RE,
    ST_BL_IM,
    ST_P_RE,
    ST_P_IM,
    ST_P_DONE,
    ST_Q_RE,
    ST_Q_IM,
    ST_Q_DONE,
    ST_T,
    ST_ACC
  } icwr_state_e;

  typedef struct packed {
    logic     load_in;
    icwr_op_e mul_op;
    icwr_op_e comb_op;
  } icwr_cmd_t;

  typedef struct packed {
    logic last;
    logic out_free;
  } icwr_sts_t;

endpackage

### src/icwr_mul.sv
module icwr_mul (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic                                 weight_shift_i,
  input  logic signed [icwr_pkg::DATA_W-1:0]   a_i,
  input  logic signed [icwr_pkg::DATA_W-1:0]   b_i,
  output logic signed [icwr_pkg::PROD_W-1:0]   prod_o
);
  import icwr_pkg::*;

  logic signed [2*DATA_W-1:0] full;
  logic signed [2*DATA_W-1:0] shifted;
  logic signed [PROD_W-1:0]   prod_q;

  assign full = a_i * b_i;

  // Truncate by an arithmetic shift (floor)
  always_comb begin
    if (weight_shift_i) begin
      shifted = full >>> WEIGHT_FRAC_BITS;
    end else begin
      shifted = full >>> DATA_FRAC_BITS;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= shifted[PROD_W-1:0];
    end
  end

  assign prod_o = prod_q;

endmodule

### src/icwr_dpath.sv
module icwr_dpath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  icwr_pkg::icwr_cmd_t                cmd_i,
  output icwr_pkg::icwr_sts_t                sts_o,
  input  logic signed [icwr_pkg::DATA_W-1:0] weight_low_i,
  input  logic signed [icwr_pkg::DATA_W-1:0] weight_high_i,
  input  logic signed [icwr_pkg::DATA_W-1:0] col_re_i,
  input  logic signed [icwr_pkg::DATA_W-1:0] col_im_i,
  input  logic signed [icwr_pkg::DATA_W-1:0] row_re_i,
  input  logic signed [icwr_pkg::DATA_W-1:0] row_im_i,
  input  logic signed [icwr_pkg::DATA_W-1:0] coul_weight_i,
  input  logic signed [icwr_pkg::DATA_W-1:0] lo_re_i,
  input  logic signed [icwr_pkg::DATA_W-1:0] lo_im_i,
  input  logic signed [icwr_pkg::DATA_W-1:0] hi_re_i,
  input  logic signed [icwr_pkg::DATA_W-1:0] hi_im_i,
  input  logic                               last_i,
  input  logic                               out_stall_i,
  output logic                               out_valid_o,
  output logic signed [icwr_pkg::ACC_W-1:0]  sum_re_o,
  output logic signed [icwr_pkg::ACC_W-1:0]  sum_im_o,
  output logic                               saturated_o
);
  import icwr_pkg::*;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-DATA_W:0] upper;
    upper = v[SUM_W-1:DATA_W-1];
    if ((&upper) || !(|upper)) begin
      return v[DATA_W-1:0];
    end else if (v[SUM_W-1]) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

  // Returns {overflow, saturated sum}
  function automatic logic [ACC_W:0] sat_add(input logic signed [ACC_W-1:0] a,
                                             input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W:0] s;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1]) begin
      if (s[ACC_W]) begin
        return {1'b1, 1'b1, {(ACC_W-1){1'b0}}};
      end else begin
        return {1'b1, 1'b0, {(ACC_W-1){1'b1}}};
      end
    end else begin
      return {1'b0, s[ACC_W-1:0]};
    end
  endfunction

  logic signed [DATA_W-1:0] cr_q, ci_q, rr_q, ri_q, cw_q, lr_q, li_q, hr_q, hi_q;
  logic                     last_q;
  logic signed [DATA_W-1:0] br_q, bi_q, pr_q, pi_q, qr_q, qi_q;
  logic signed [ACC_W-1:0]  acc_re_q, acc_re_d, acc_im_q, acc_im_d;
  logic                     sat_q, sat_d;
  logic                     out_valid_q, out_valid_d;
  logic signed [ACC_W-1:0]  sum_re_q, sum_im_q;
  logic                     out_sat_q;

  logic signed [DATA_W-1:0] m0_a, m0_b, m1_a, m1_b;
  logic                     mul_en, weight_shift;
  logic signed [PROD_W-1:0] p0, p1;
  logic signed [SUM_W-1:0]  comb_sum;
  logic signed [DATA_W-1:0] comb_sat;
  logic [ACC_W:0]           add_re, add_im;
  logic                     take_out, emit;

  // Input capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      cr_q   <= col_re_i;
      ci_q   <= col_im_i;
      rr_q   <= row_re_i;
      ri_q   <= row_im_i;
      cw_q   <= coul_weight_i;
      lr_q   <= lo_re_i;
      li_q   <= lo_im_i;
      hr_q   <= hi_re_i;
      hi_q   <= hi_im_i;
      last_q <= last_i;
    end
  end

  // Operand selection for the multiplier pair
  always_comb begin
    m0_a         = cr_q;
    m0_b         = rr_q;
    m1_a         = ci_q;
    m1_b         = ri_q;
    weight_shift = 1'b0;
    unique case (cmd_i.mul_op)
      MOP_BL_RE: begin
        m0_a = lr_q; m0_b = weight_low_i;
        m1_a = hr_q; m1_b = weight_high_i;
        weight_shift = 1'b1;
      end
      MOP_BL_IM: begin
        m0_a = li_q; m0_b = weight_low_i;
        m1_a = hi_q; m1_b = weight_high_i;
        weight_shift = 1'b1;
      end
      MOP_P_RE: begin
        m0_a = cr_q; m0_b = rr_q;
        m1_a = ci_q; m1_b = ri_q;
      end
      MOP_P_IM: begin
        m0_a = ci_q; m0_b = rr_q;
        m1_a = cr_q; m1_b = ri_q;
      end
      MOP_Q_RE: begin
        m0_a = pr_q; m0_b = br_q;
        m1_a = pi_q; m1_b = bi_q;
      end
      MOP_Q_IM: begin
        m0_a = pr_q; m0_b = bi_q;
        m1_a = pi_q; m1_b = br_q;
      end
      MOP_T: begin
        m0_a = qr_q; m0_b = cw_q;
        m1_a = qi_q; m1_b = cw_q;
      end
      MOP_NONE: begin
      end
      default: begin
      end
    endcase
  end

  assign mul_en = (cmd_i.mul_op != MOP_NONE);

  icwr_mul u_mul0 (
    .clk_i          (clk_i),
    .en_i           (mul_en),
    .weight_shift_i (weight_shift),
    .a_i            (m0_a),
    .b_i            (m0_b),
    .prod_o         (p0)
  );

  icwr_mul u_mul1 (
    .clk_i          (clk_i),
    .en_i           (mul_en),
    .weight_shift_i (weight_shift),
    .a_i            (m1_a),
    .b_i            (m1_b),
    .prod_o         (p1)
  );

  // Combine the registered products: difference for the conjugate and i*i terms
  always_comb begin
    if ((cmd_i.comb_op == MOP_P_IM) || (cmd_i.comb_op == MOP_Q_RE)) begin
      comb_sum = {p0[PROD_W-1], p0} - {p1[PROD_W-1], p1};
    end else begin
      comb_sum = {p0[PROD_W-1], p0} + {p1[PROD_W-1], p1};
    end
    comb_sat = sat32(comb_sum);
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.comb_op)
      MOP_BL_RE: br_q <= comb_sat;
      MOP_BL_IM: bi_q <= comb_sat;
      MOP_P_RE:  pr_q <= comb_sat;
      MOP_P_IM:  pi_q <= comb_sat;
      MOP_Q_RE:  qr_q <= comb_sat;
      MOP_Q_IM:  qi_q <= comb_sat;
      MOP_T, MOP_NONE: begin
      end
      default: begin
      end
    endcase
  end

  // Accumulate
  assign add_re   = sat_add(acc_re_q, {{(ACC_W-PROD_W){p0[PROD_W-1]}}, p0});
  assign add_im   = sat_add(acc_im_q, {{(ACC_W-PROD_W){p1[PROD_W-1]}}, p1});
  assign emit     = (cmd_i.comb_op == MOP_T) && last_q;
  assign take_out = out_valid_q && !out_stall_i;

  always_comb begin
    acc_re_d    = acc_re_q;
    acc_im_d    = acc_im_q;
    sat_d       = sat_q;
    out_valid_d = out_valid_q && !take_out;
    if (cmd_i.comb_op == MOP_T) begin
      if (last_q) begin
        acc_re_d    = '0;
        acc_im_d    = '0;
        sat_d       = 1'b0;
        out_valid_d = 1'b1;
      end else begin
        acc_re_d = add_re[ACC_W-1:0];
        acc_im_d = add_im[ACC_W-1:0];
        sat_d    = sat_q | add_re[ACC_W] | add_im[ACC_W];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_re_q    <= '0;
      acc_im_q    <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      acc_re_q    <= acc_re_d;
      acc_im_q    <= acc_im_d;
      sat_q       <= sat_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      sum_re_q  <= add_re[ACC_W-1:0];
      sum_im_q  <= add_im[ACC_W-1:0];
      out_sat_q <= sat_q | add_re[ACC_W] | add_im[ACC_W];
    end
  end

  assign sts_o.last     = last_q;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign sum_re_o    = sum_re_q;
  assign sum_im_o    = sum_im_q;
  assign saturated_o = out_sat_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(emit && out_valid_q && out_stall_i))
    else $error("result register overwritten while stalled");

  a_clear_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (acc_re_q == '0) && (acc_im_q == '0) && !sat_q && out_valid_q)
    else $error("accumulator not cleared after final term");

endmodule

### src/icwr_ctrl.sv
module icwr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  icwr_pkg::icwr_sts_t sts_i,
  output icwr_pkg::icwr_cmd_t cmd_o
);
  import icwr_pkg::*;

  icwr_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o.load_in = 1'b0;
    cmd_o.mul_op  = MOP_NONE;
    cmd_o.comb_op = MOP_NONE;
    in_stall_o    = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.load_in = in_valid_i;
        if (in_valid_i) state_d = ST_BL_RE;
      end
      ST_BL_RE: begin
        cmd_o.mul_op = MOP_BL_RE;
        state_d      = ST_BL_IM;
      end
      ST_BL_IM: begin
        cmd_o.mul_op  = MOP_BL_IM;
        cmd_o.comb_op = MOP_BL_RE;
        state_d       = ST_P_RE;
      end
      ST_P_RE: begin
        cmd_o.mul_op  = MOP_P_RE;
        cmd_o.comb_op = MOP_BL_IM;
        state_d       = ST_P_IM;
      end
      ST_P_IM: begin
        cmd_o.mul_op  = MOP_P_IM;
        cmd_o.comb_op = MOP_P_RE;
        state_d       = ST_P_DONE;
      end
      ST_P_DONE: begin
        cmd_o.comb_op = MOP_P_IM;
        state_d       = ST_Q_RE;
      end
      ST_Q_RE: begin
        cmd_o.mul_op = MOP_Q_RE;
        state_d      = ST_Q_IM;
      end
      ST_Q_IM: begin
        cmd_o.mul_op  = MOP_Q_IM;
        cmd_o.comb_op = MOP_Q_RE;
        state_d       = ST_Q_DONE;
      end
      ST_Q_DONE: begin
        cmd_o.comb_op = MOP_Q_IM;
        state_d       = ST_T;
      end
      ST_T: begin
        cmd_o.mul_op = MOP_T;
        state_d      = ST_ACC;
      end
      ST_ACC: begin
        // Hold a final term until the result register is free
        if (!sts_i.last || sts_i.out_free) begin
          cmd_o.comb_op = MOP_T;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  a_start_on_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BL_RE) |-> $past(in_valid_i && !in_stall_o))
    else $error("sequence started without an accepted request");

endmodule

### src/interp_complex_weighted_reduce.sv
// Channel   Direction  Handshake                Payload
// in        sink       in_valid_i / in_stall_o  col/row/coul_weight/lo/hi fields, last_i
// out       source     out_valid_o / out_stall_i sum_re_o, sum_im_o, saturated_o
// cfg       sink       APB psel/penable/pwrite  weight_low (0x0), weight_high (0x4)
//
// A request is taken only in idle, and the next one only once the current one has passed
// through seven multiplier-pair issues on the two shared 32x32 multipliers plus the
// dependency bubbles of the blend -> col*conj(row) -> product -> weight chain.
// A final term appears on the output at the edge that ends its accumulate step.
// rst_ni clears the accumulator, the sticky saturation flag, the output valid
// and restores weight_low to 1.0 and weight_high to 0.
// While a result is stalled the next reduction keeps running; only its final term
// holds in the accumulate step until the output register frees.
module interp_complex_weighted_reduce (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [icwr_pkg::PADDR_W-1:0]        paddr,
  input  logic [icwr_pkg::PDATA_W-1:0]        pwdata,
  output logic [icwr_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready,
  // term input
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [icwr_pkg::DATA_W-1:0]  col_re_i,
  input  logic signed [icwr_pkg::DATA_W-1:0]  col_im_i,
  input  logic signed [icwr_pkg::DATA_W-1:0]  row_re_i,
  input  logic signed [icwr_pkg::DATA_W-1:0]  row_im_i,
  input  logic signed [icwr_pkg::DATA_W-1:0]  coul_weight_i,
  input  logic signed [icwr_pkg::DATA_W-1:0]  lo_re_i,
  input  logic signed [icwr_pkg::DATA_W-1:0]  lo_im_i,
  input  logic signed [icwr_pkg::DATA_W-1:0]  hi_re_i,
  input  logic signed [icwr_pkg::DATA_W-1:0]  hi_im_i,
  input  logic                                last_i,
  // result output
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [icwr_pkg::ACC_W-1:0]   sum_re_o,
  output logic signed [icwr_pkg::ACC_W-1:0]   sum_im_o,
  output logic                                saturated_o
);
  import icwr_pkg::*;

  logic [DATA_W-1:0] weight_low_q, weight_high_q;
  logic              reg_idx;
  logic              cfg_write;
  icwr_cmd_t         cmd;
  icwr_sts_t         sts;

  // Word-addressed registers: byte-lane bits are ignored
  assign reg_idx   = paddr[2];
  assign cfg_write = psel && penable && pwrite;
  assign pready    = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_low_q  <= WEIGHT_LOW_RESET;
      weight_high_q <= WEIGHT_HIGH_RESET;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_IDX_WEIGHT_LOW:  weight_low_q  <= pwdata;
        REG_IDX_WEIGHT_HIGH: weight_high_q <= pwdata;
        default: begin
        end
      endcase
    end
  end

  // Read back the addressed weight
  always_comb begin
    unique case (reg_idx)
      REG_IDX_WEIGHT_LOW:  prdata = weight_low_q;
      REG_IDX_WEIGHT_HIGH: prdata = weight_high_q;
      default:             prdata = '0;
    endcase
  end

  icwr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  icwr_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .weight_low_i  (weight_low_q),
    .weight_high_i (weight_high_q),
    .col_re_i      (col_re_i),
    .col_im_i      (col_im_i),
    .row_re_i      (row_re_i),
    .row_im_i      (row_im_i),
    .coul_weight_i (coul_weight_i),
    .lo_re_i       (lo_re_i),
    .lo_im_i       (lo_im_i),
    .hi_re_i       (hi_re_i),
    .hi_im_i       (hi_im_i),
    .last_i        (last_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .sum_re_o      (sum_re_o),
    .sum_im_o      (sum_im_o),
    .saturated_o   (saturated_o)
  );

endmodule

### dv/tb_interp_complex_weighted_reduce.sv
module tb_interp_complex_weighted_reduce;
  timeunit 1ns;
  timeprecision 1ps;

  import icwr_pkg::*;

  // Register map: one 32-bit weight every four bytes
  localparam logic [PADDR_W-1:0] ADDR_WEIGHT_LOW  = {REG_IDX_WEIGHT_LOW, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_WEIGHT_HIGH = {REG_IDX_WEIGHT_HIGH, 2'b00};

  // Handy Q8.24 values
  localparam logic [DATA_W-1:0] Q_ONE  = 32'h0100_0000;
  localparam logic [DATA_W-1:0] Q_HALF = 32'h0080_0000;
  localparam logic [DATA_W-1:0] Q_MAX  = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] Q_MIN  = 32'h8000_0000;
  localparam logic [DATA_W-1:0] Q_LSB  = 32'h0000_0001;
  localparam logic [DATA_W-1:0] Q_NEG  = 32'hFFFF_FFFF;

  localparam longint ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint ACC_MIN = 64'sh8000_0000_0000_0000;

  localparam int IDLE_PCT      = 25;
  localparam int HOLD_CYCLES   = 400;   // receiver hold-off, long enough to back up the input
  localparam int SETTLE_CYCLES = 40;    // several times the request spacing
  localparam int PHASE_TERMS   = 192;
  localparam int NUM_SETTINGS  = 8;
  localparam int CYCLE_LIMIT   = 500000;

  typedef struct packed {
    logic signed [DATA_W-1:0] col_re;
    logic signed [DATA_W-1:0] col_im;
    logic signed [DATA_W-1:0] row_re;
    logic signed [DATA_W-1:0] row_im;
    logic signed [DATA_W-1:0] coul_weight;
    logic signed [DATA_W-1:0] lo_re;
    logic signed [DATA_W-1:0] lo_im;
    logic signed [DATA_W-1:0] hi_re;
    logic signed [DATA_W-1:0] hi_im;
    logic                     last;
  } term_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] re;
    logic signed [ACC_W-1:0] im;
    logic                    sat;
  } sum_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [PADDR_W-1:0]  paddr   = '0;
  logic [PDATA_W-1:0]  pwdata  = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  logic                      in_valid_i  = 1'b0;
  logic                      in_stall_o;
  logic signed [DATA_W-1:0]  col_re_i, col_im_i, row_re_i, row_im_i, coul_weight_i;
  logic signed [DATA_W-1:0]  lo_re_i, lo_im_i, hi_re_i, hi_im_i;
  logic                      last_i;

  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic signed [ACC_W-1:0]   sum_re_o, sum_im_o;
  logic                      saturated_o;

  // Pending requests and the sums they are predicted to produce
  term_t term_q[$];
  sum_t  sum_q[$];
  term_t term_cur = '0;
  logic  term_taken = 1'b0;

  // Predictor state: its own copy of the weights and the accumulator
  logic signed [DATA_W-1:0] wt_low  = WEIGHT_LOW_RESET;
  logic signed [DATA_W-1:0] wt_high = WEIGHT_HIGH_RESET;
  longint acc_re  = 0;
  longint acc_im  = 0;
  logic   acc_sat = 1'b0;

  int unsigned terms_queued = 0;
  int unsigned terms_done   = 0;
  int unsigned sums_checked = 0;
  int unsigned errors       = 0;
  int unsigned cycles       = 0;
  int unsigned stall_run    = 0;
  int unsigned stall_peak   = 0;

  bit send_calm = 1'b0;
  bit recv_calm = 1'b0;
  int unsigned hold_asks = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  assign col_re_i      = term_cur.col_re;
  assign col_im_i      = term_cur.col_im;
  assign row_re_i      = term_cur.row_re;
  assign row_im_i      = term_cur.row_im;
  assign coul_weight_i = term_cur.coul_weight;
  assign lo_re_i       = term_cur.lo_re;
  assign lo_im_i       = term_cur.lo_im;
  assign hi_re_i       = term_cur.hi_re;
  assign hi_im_i       = term_cur.hi_im;
  assign last_i        = term_cur.last;

  interp_complex_weighted_reduce DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .col_re_i      (col_re_i),
    .col_im_i      (col_im_i),
    .row_re_i      (row_re_i),
    .row_im_i      (row_im_i),
    .coul_weight_i (coul_weight_i),
    .lo_re_i       (lo_re_i),
    .lo_im_i       (lo_im_i),
    .hi_re_i       (hi_re_i),
    .hi_im_i       (hi_im_i),
    .last_i        (last_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .sum_re_o      (sum_re_o),
    .sum_im_o      (sum_im_o),
    .saturated_o   (saturated_o)
  );

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Fixed-point predictor
  // ---------------------------------------------------------------------------

  // Exact 64-bit product, then floor by an arithmetic shift
  function automatic longint scaled_mul(longint a, longint b, int unsigned sh);
    return (a * b) >>> sh;
  endfunction

  function automatic longint clamp32(longint x);
    if (x > 64'sd2147483647)  return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // Saturating accumulate; any overflow sets the sticky flag for this reduction
  function automatic longint sat_acc(longint a, longint b);
    longint s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      acc_sat = 1'b1;
      return b[63] ? ACC_MIN : ACC_MAX;
    end
    return s;
  endfunction

  // Advance the predictor by one accepted term; queue the sum on the final one
  function automatic void accumulate_term(term_t t);
    longint cr, ci, rr, ri, cw, lr, li, hr, hi, wl, wh;
    longint br, bi, pr, pi, qr, qi;
    cr = longint'(t.col_re);
    ci = longint'(t.col_im);
    rr = longint'(t.row_re);
    ri = longint'(t.row_im);
    cw = longint'(t.coul_weight);
    lr = longint'(t.lo_re);
    li = longint'(t.lo_im);
    hr = longint'(t.hi_re);
    hi = longint'(t.hi_im);
    wl = longint'(wt_low);
    wh = longint'(wt_high);

    // blend of the two slices
    br = clamp32(scaled_mul(lr, wl, WEIGHT_FRAC_BITS) + scaled_mul(hr, wh, WEIGHT_FRAC_BITS));
    bi = clamp32(scaled_mul(li, wl, WEIGHT_FRAC_BITS) + scaled_mul(hi, wh, WEIGHT_FRAC_BITS));
    // column times conjugated row
    pr = clamp32(scaled_mul(cr, rr, DATA_FRAC_BITS) + scaled_mul(ci, ri, DATA_FRAC_BITS));
    pi = clamp32(scaled_mul(ci, rr, DATA_FRAC_BITS) - scaled_mul(cr, ri, DATA_FRAC_BITS));
    // times the blended sample
    qr = clamp32(scaled_mul(pr, br, DATA_FRAC_BITS) - scaled_mul(pi, bi, DATA_FRAC_BITS));
    qi = clamp32(scaled_mul(pr, bi, DATA_FRAC_BITS) + scaled_mul(pi, br, DATA_FRAC_BITS));
    // times the real term weight, kept at full width
    acc_re = sat_acc(acc_re, scaled_mul(qr, cw, DATA_FRAC_BITS));
    acc_im = sat_acc(acc_im, scaled_mul(qi, cw, DATA_FRAC_BITS));

    if (t.last) begin
      sum_q.push_back('{re: acc_re, im: acc_im, sat: acc_sat});
      acc_re  = 0;
      acc_im  = 0;
      acc_sat = 1'b0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void add_term(logic [DATA_W-1:0] cr, logic [DATA_W-1:0] ci,
                                   logic [DATA_W-1:0] rr, logic [DATA_W-1:0] ri,
                                   logic [DATA_W-1:0] cw,
                                   logic [DATA_W-1:0] lr, logic [DATA_W-1:0] li,
                                   logic [DATA_W-1:0] hr, logic [DATA_W-1:0] hi,
                                   logic last);
    term_q.push_back('{cr, ci, rr, ri, cw, lr, li, hr, hi, last});
    terms_queued++;
  endfunction

  // Mix of rails, zero, full-range noise and moderate values that stay clear of the clamps
  function automatic logic [DATA_W-1:0] pick_word();
    int unsigned sel = $urandom_range(15);
    if (sel == 0) return Q_MAX;
    if (sel == 1) return Q_MIN;
    if (sel == 2) return '0;
    if (sel < 8)  return $urandom;
    return $urandom_range(32'h0400_0000) - 32'h0200_0000;
  endfunction

  // Queue whole reductions of random terms, mostly short, now and then long
  function automatic void add_reductions(int unsigned n_terms);
    int unsigned pushed = 0;
    int unsigned len;
    while (pushed < n_terms) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 6);
      for (int unsigned k = 0; k < len; k++) begin
        add_term(pick_word(), pick_word(), pick_word(), pick_word(), pick_word(),
                 pick_word(), pick_word(), pick_word(), pick_word(), k == len - 1);
      end
      pushed += len;
    end
  endfunction

  // APB: setup cycle, then access until pready; data sampled at the completing edge
  task automatic cfg_access(input logic wr, input logic [PADDR_W-1:0] addr,
                            input logic [PDATA_W-1:0] wdata, output logic [PDATA_W-1:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_reg(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] want);
    logic [PDATA_W-1:0] got;
    cfg_access(1'b0, addr, '0, got);
    if (got !== want) begin
      $error("prdata @%0h: expected %0h, actual %0h", addr, want, got);
      errors++;
    end
  endtask

  task automatic set_weights(input logic [PDATA_W-1:0] lo_w, input logic [PDATA_W-1:0] hi_w);
    logic [PDATA_W-1:0] unused;
    cfg_access(1'b1, ADDR_WEIGHT_LOW, lo_w, unused);
    cfg_access(1'b1, ADDR_WEIGHT_HIGH, hi_w, unused);
    wt_low  = lo_w;
    wt_high = hi_w;
    check_reg(ADDR_WEIGHT_LOW, lo_w);
    check_reg(ADDR_WEIGHT_HIGH, hi_w);
  endtask

  // Hold until every queued term is predicted and every sum is back, then let the
  // block settle for SETTLE_CYCLES before touching the registers
  task automatic wait_drained();
    while (terms_done != terms_queued || sum_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic void compare_field(string name, longint want, longint got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver
  // ---------------------------------------------------------------------------

  // Sample the input handshake on the rising edge; also track how long the
  // block keeps an offered request waiting
  always @(posedge clk_i) begin
    term_taken <= rst_ni && in_valid_i && !in_stall_o;
    if (in_valid_i && in_stall_o) begin
      stall_run++;
      if (stall_run > stall_peak) stall_peak = stall_run;
    end else begin
      stall_run = 0;
    end
  end

  // Drive on the falling edge. A request that is offered stays put until taken;
  // the idle decision is made only between requests, never from the stall.
  always @(negedge clk_i) begin
    bit offer;
    offer = in_valid_i && !term_taken;
    if (term_taken) begin
      accumulate_term(term_cur);
      terms_done++;
    end
    if (!offer && rst_ni && term_q.size() > 0 &&
        (send_calm || $urandom_range(99) >= IDLE_PCT)) begin
      term_cur = term_q.pop_front();
      offer    = 1'b1;
    end
    in_valid_i <= offer;
  end

  // ---------------------------------------------------------------------------
  // Result receiver and checker
  // ---------------------------------------------------------------------------

  // Random stalls, none at all when calm, and a counted hold-off on request
  always @(negedge clk_i) begin
    if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !recv_calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Compare each accepted sum against the oldest prediction
  always @(posedge clk_i) begin
    sum_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (sum_q.size() == 0) begin
        $error("unexpected result: sum_re=%0d sum_im=%0d saturated=%0b",
               sum_re_o, sum_im_o, saturated_o);
        errors++;
      end else begin
        want = sum_q.pop_front();
        compare_field("sum_re", want.re, sum_re_o);
        compare_field("sum_im", want.im, sum_im_o);
        compare_field("saturated", longint'(want.sat), longint'(saturated_o));
        sums_checked++;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  initial begin
    logic [PDATA_W-1:0] lo_w, hi_w;

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Registers must come out of reset at 1.0 and 0
    check_reg(ADDR_WEIGHT_LOW, WEIGHT_LOW_RESET);
    check_reg(ADDR_WEIGHT_HIGH, WEIGHT_HIGH_RESET);

    // Directed terms under reset weights: upper slice ignored
    // zero term closing an empty reduction
    add_term('0, '0, '0, '0, '0, '0, '0, '0, '0, 1'b1);
    // unity path; the upper slice is at its rails but weighted by zero
    add_term(Q_ONE, '0, Q_ONE, '0, Q_ONE, Q_ONE, Q_HALF, Q_MAX, Q_MIN, 1'b1);
    // i times conj(i) gives one
    add_term('0, Q_ONE, '0, Q_ONE, Q_ONE, Q_ONE, '0, '0, '0, 1'b1);
    // one times conj(i) gives -i; times i gives one
    add_term(Q_ONE, '0, '0, Q_ONE, Q_ONE, '0, Q_ONE, '0, '0, 1'b1);
    // floor truncation of tiny negative products
    add_term(Q_NEG, Q_LSB, Q_LSB, Q_NEG, Q_ONE, Q_ONE, Q_NEG, '0, '0, 1'b1);
    // rails everywhere: clamps on p and q
    add_term(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b0);
    add_term(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b0);
    add_term(Q_MAX, Q_MIN, Q_MIN, Q_MAX, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MIN, 1'b1);
    // largest term magnitude: clamped q times the most negative weight
    add_term(Q_MAX, '0, Q_MAX, '0, Q_MIN, Q_MAX, Q_MIN, '0, '0, 1'b1);
    // several terms accumulate before the final one
    for (int k = 0; k < 5; k++) begin
      add_term(Q_ONE, Q_HALF, Q_HALF, Q_ONE, Q_ONE, Q_ONE, Q_NEG, '0, '0, k == 4);
    end
    // cancelling pair within one reduction
    add_term(Q_ONE, '0, Q_ONE, '0, Q_ONE, Q_MAX, Q_MAX, '0, '0, 1'b0);
    add_term(Q_ONE, '0, Q_ONE, '0, Q_NEG ^ Q_ONE, Q_MAX, Q_MAX, '0, '0, 1'b1);
    wait_drained();

    // Random reductions across weight settings; each write only with the block idle
    for (int s = 0; s < NUM_SETTINGS; s++) begin
      case (s)
        0: begin lo_w = WEIGHT_LOW_RESET; hi_w = WEIGHT_HIGH_RESET; end
        1: begin lo_w = 32'h7FFF_FFFF;    hi_w = 32'h8000_0000;     end
        2: begin lo_w = 32'h8000_0000;    hi_w = 32'h7FFF_FFFF;     end
        3: begin lo_w = 32'h0000_0000;    hi_w = 32'h4000_0000;     end
        4: begin lo_w = 32'h2000_0000;    hi_w = 32'h2000_0000;     end
        5: begin lo_w = 32'h8000_0000;    hi_w = 32'h8000_0000;     end
        6: begin lo_w = 32'h7FFF_FFFF;    hi_w = 32'h7FFF_FFFF;     end
        default: begin lo_w = $urandom; hi_w = $urandom; end
      endcase
      set_weights(lo_w, hi_w);

      // one phase runs flat out on both sides
      send_calm = (s == 3);
      recv_calm = (s == 3);
      add_reductions(PHASE_TERMS);
      // stall the output for a long stretch while requests keep coming
      if (s == 1) hold_asks++;
      wait_drained();
    end

    $display("Checked %0d sums from %0d terms over %0d weight settings plus reset weights",
             sums_checked, terms_done, NUM_SETTINGS);
    $display("Longest input back-pressure on an offered request: %0d cycles", stall_peak);
    if (errors == 0 && sum_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
